// ===== sv/nmea_rmc_pkg.sv =====
// Package for the NMEA RMC line checker: character codes, class codes,
// the per-line parse state type and the hex digit decoder.
// No dependencies.
`timescale 1ns / 1ps

package nmea_rmc_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // Header strings, first character in the top byte.
    localparam logic [47:0] HDR_GP = "$GPRMC";
    localparam logic [47:0] HDR_GN = "$GNRMC";
    localparam logic [2:0]  HDR_LEN = 3'd6;
    localparam logic [2:0]  HDR_CNT_MAX = 3'd7;

    localparam logic [1:0] FIELD_HEADER = 2'd0;
    localparam logic [1:0] FIELD_STATUS = 2'd2;
    localparam logic [1:0] FIELD_MAX    = 2'd3;

    localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;

    // Lines of this many stored bytes or fewer give no result.
    localparam int SHORT_LINE_MAX = 5;

    localparam logic [1:0] CLASS_BAD_SUM = 2'd0;
    localparam logic [1:0] CLASS_NOT_RMC = 2'd1;
    localparam logic [1:0] CLASS_VOID    = 2'd2;
    localparam logic [1:0] CLASS_ACTIVE  = 2'd3;

    typedef struct packed {
        logic [7:0] xor_acc;
        logic       starts_dollar;
        logic       content_ended;
        logic       star_seen;
        logic [1:0] hex_count;
        logic       hex_stopped;
        logic [7:0] expected_sum;
        logic [1:0] field_num;
        logic [2:0] hdr_count;
        logic       hdr_gp_match;
        logic       hdr_gn_match;
        logic [7:0] status_char;
        logic       status_taken;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        xor_acc:       8'h00,
        starts_dollar: 1'b0,
        content_ended: 1'b0,
        star_seen:     1'b0,
        hex_count:     2'd0,
        hex_stopped:   1'b0,
        expected_sum:  8'h00,
        field_num:     2'd0,
        hdr_count:     3'd0,
        hdr_gp_match:  1'b1,
        hdr_gn_match:  1'b1,
        status_char:   8'h00,
        status_taken:  1'b0
    };

    // Returns {is_hex, value}; either case of letter is accepted.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

// ===== sv/nmea_rmc_line_checker.sv =====
// Top level of the NMEA RMC line checker: byte parser and result register.
// Depends on nmea_rmc_pkg.
// A result shows in the cycle after its terminator is accepted.
// Throughput: one byte per cycle; a result held back by the receiver stalls
// input until it is taken, and a byte is accepted in the cycle it leaves.
// Reset: asynchronous, active low; clears the line state and drops any result.
`timescale 1ns / 1ps

module nmea_rmc_line_checker
    import nmea_rmc_pkg::*;
#(
    parameter int LINE_CAPACITY = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] line_class,
    output logic [6:0] line_length
);

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] COUNT_LAST = CW'(LINE_CAPACITY - 1);
    localparam logic [CW-1:0] COUNT_SHORT = CW'(SHORT_LINE_MAX);

    logic [CW-1:0] count_reg, count_next;
    line_state_t   line_reg, line_next;
    logic          out_valid_reg;
    logic [1:0]    class_reg, class_next;
    logic [6:0]    length_reg, length_next;
    logic          emit;
    logic          in_fire;
    logic          is_term;
    logic [4:0]    hex;
    logic [CW+6:0] count_ext;
    logic [7:0]    gp_char;
    logic [7:0]    gn_char;
    logic          sum_ok;
    logic          is_rmc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_term  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign hex      = hex_decode(rx_byte);
    assign count_ext = {7'd0, count_reg};

    assign gp_char = HDR_GP[47 - 8*line_reg.hdr_count -: 8];
    assign gn_char = HDR_GN[47 - 8*line_reg.hdr_count -: 8];

    assign sum_ok = line_reg.starts_dollar && line_reg.star_seen
                    && (line_reg.xor_acc == line_reg.expected_sum);
    assign is_rmc = (line_reg.hdr_count == HDR_LEN)
                    && (line_reg.hdr_gp_match || line_reg.hdr_gn_match);

    always_comb
    begin
        count_next  = count_reg;
        line_next   = line_reg;
        emit        = 1'b0;
        length_next = count_ext[6:0];
        if (!sum_ok) begin
            class_next = CLASS_BAD_SUM;
        end
        else if (!is_rmc) begin
            class_next = CLASS_NOT_RMC;
        end
        else if (line_reg.status_taken && line_reg.status_char == CHAR_A) begin
            class_next = CLASS_ACTIVE;
        end
        else begin
            class_next = CLASS_VOID;
        end

        if (in_fire) begin
            if (is_term) begin
                emit       = (count_reg > COUNT_SHORT);
                count_next = '0;
                line_next  = LINE_CLEAR;
            end
            else if (count_reg >= COUNT_LAST) begin
                // Overlong line: drop the byte and start over.
                count_next = '0;
                line_next  = LINE_CLEAR;
            end
            else begin
                count_next = count_reg + 1'b1;
                if (!line_reg.content_ended) begin
                    if (rx_byte == CHAR_NUL) begin
                        line_next.content_ended = 1'b1;
                    end
                    else begin
                        if (count_reg == '0) begin
                            line_next.starts_dollar = (rx_byte == CHAR_DOLLAR);
                        end
                        if (line_reg.star_seen) begin
                            if (!line_reg.hex_stopped
                                && line_reg.hex_count < HEX_DIGITS_MAX) begin
                                if (!hex[4]) begin
                                    line_next.hex_stopped = 1'b1;
                                end
                                else begin
                                    line_next.expected_sum =
                                        {line_reg.expected_sum[3:0], hex[3:0]};
                                    line_next.hex_count = line_reg.hex_count + 2'd1;
                                end
                            end
                        end
                        else if (rx_byte == CHAR_STAR) begin
                            line_next.star_seen = 1'b1;
                        end
                        else begin
                            // The leading byte is not part of the checksum.
                            if (count_reg != '0) begin
                                line_next.xor_acc = line_reg.xor_acc ^ rx_byte;
                            end
                            if (rx_byte == CHAR_COMMA) begin
                                if (line_reg.field_num < FIELD_MAX) begin
                                    line_next.field_num = line_reg.field_num + 2'd1;
                                end
                            end
                            else if (line_reg.field_num == FIELD_HEADER) begin
                                if (line_reg.hdr_count < HDR_LEN) begin
                                    if (rx_byte != gp_char) begin
                                        line_next.hdr_gp_match = 1'b0;
                                    end
                                    if (rx_byte != gn_char) begin
                                        line_next.hdr_gn_match = 1'b0;
                                    end
                                end
                                if (line_reg.hdr_count < HDR_CNT_MAX) begin
                                    line_next.hdr_count = line_reg.hdr_count + 3'd1;
                                end
                            end
                            else if (line_reg.field_num == FIELD_STATUS
                                     && !line_reg.status_taken) begin
                                line_next.status_char  = rx_byte;
                                line_next.status_taken = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            line_reg      <= LINE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else begin
            count_reg <= count_next;
            line_reg  <= line_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            class_reg  <= class_next;
            length_reg <= length_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_class  = class_reg;
    assign line_length = length_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for nmea_rmc_line_checker: drives byte streams of
// directed and random GPS sentences and checks each line result in order.
// Depends on nmea_rmc_pkg and the nmea_rmc_line_checker RTL.
`timescale 1ns / 1ps

module testbench
    import nmea_rmc_pkg::*;
();

    localparam int LINE_CAP    = 128;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [1:0] cls;
        logic [6:0] len;
    } line_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] line_class;
    logic [6:0] line_length;

    line_result_t pending_lines[$];
    line_result_t want;
    line_state_t  parse_st;
    int           line_bytes;
    int           bytes_sent;
    int           results_seen;
    int           class_hits[4];
    int           mismatches;
    int           cycle_count;
    bit           in_gaps_on;
    bit           out_stalls_on;

    nmea_rmc_line_checker #(
        .LINE_CAPACITY(LINE_CAP)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_class (line_class),
        .line_length(line_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         pending_lines.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver back-pressure in random bursts.
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_stalls_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lines.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual class %0d length %0d",
                         $time, line_class, line_length);
                mismatches++;
            end
            else
            begin
                want = pending_lines.pop_front();
                results_seen++;
                class_hits[want.cls]++;
                if (line_class !== want.cls)
                begin
                    $display("%0t: line_class mismatch, expected %0d, actual %0d",
                             $time, want.cls, line_class);
                    mismatches++;
                end
                if (line_length !== want.len)
                begin
                    $display("%0t: line_length mismatch, expected %0d, actual %0d",
                             $time, want.len, line_length);
                    mismatches++;
                end
            end
        end
    end

    // Tracks the parse of the current line and queues the result that a
    // terminator produces.
    task automatic predict_line_result(input logic [7:0] b);
        line_result_t r;
        bit           sum_good;
        bit           rmc;
        int           nib;
        if (b == CHAR_LF || b == CHAR_CR)
        begin
            if (line_bytes > SHORT_LINE_MAX)
            begin
                sum_good = parse_st.starts_dollar && parse_st.star_seen &&
                           (parse_st.xor_acc == parse_st.expected_sum);
                rmc = (parse_st.hdr_count == HDR_LEN) &&
                      (parse_st.hdr_gp_match || parse_st.hdr_gn_match);
                if (!sum_good)
                    r.cls = CLASS_BAD_SUM;
                else if (!rmc)
                    r.cls = CLASS_NOT_RMC;
                else if (parse_st.status_taken && parse_st.status_char == CHAR_A)
                    r.cls = CLASS_ACTIVE;
                else
                    r.cls = CLASS_VOID;
                r.len = line_bytes[6:0];
                pending_lines.push_back(r);
            end
            parse_st = LINE_CLEAR;
            line_bytes = 0;
            return;
        end
        // A byte that would overflow the line buffer is lost and the line restarts.
        if (line_bytes >= LINE_CAP - 1)
        begin
            parse_st = LINE_CLEAR;
            line_bytes = 0;
            return;
        end
        if (!parse_st.content_ended)
        begin
            if (b == CHAR_NUL)
                parse_st.content_ended = 1'b1;
            else
            begin
                if (line_bytes == 0)
                    parse_st.starts_dollar = (b == CHAR_DOLLAR);
                if (parse_st.star_seen)
                begin
                    if (!parse_st.hex_stopped && parse_st.hex_count < HEX_DIGITS_MAX)
                    begin
                        nib = -1;
                        if (b >= "0" && b <= "9")
                            nib = b - "0";
                        else if (b >= "A" && b <= "F")
                            nib = b - "A" + 10;
                        else if (b >= "a" && b <= "f")
                            nib = b - "a" + 10;
                        if (nib < 0)
                            parse_st.hex_stopped = 1'b1;
                        else
                        begin
                            parse_st.expected_sum = {parse_st.expected_sum[3:0], nib[3:0]};
                            parse_st.hex_count = parse_st.hex_count + 2'd1;
                        end
                    end
                end
                else if (b == CHAR_STAR)
                    parse_st.star_seen = 1'b1;
                else
                begin
                    if (line_bytes >= 1)
                        parse_st.xor_acc = parse_st.xor_acc ^ b;
                    if (b == CHAR_COMMA)
                    begin
                        if (parse_st.field_num < FIELD_MAX)
                            parse_st.field_num = parse_st.field_num + 2'd1;
                    end
                    else if (parse_st.field_num == FIELD_HEADER)
                    begin
                        if (parse_st.hdr_count < HDR_LEN)
                        begin
                            if (b != HDR_GP[8 * (5 - parse_st.hdr_count) +: 8])
                                parse_st.hdr_gp_match = 1'b0;
                            if (b != HDR_GN[8 * (5 - parse_st.hdr_count) +: 8])
                                parse_st.hdr_gn_match = 1'b0;
                        end
                        if (parse_st.hdr_count < HDR_CNT_MAX)
                            parse_st.hdr_count = parse_st.hdr_count + 3'd1;
                    end
                    else if (parse_st.field_num == FIELD_STATUS && !parse_st.status_taken)
                    begin
                        parse_st.status_char = b;
                        parse_st.status_taken = 1'b1;
                    end
                end
            end
        end
        line_bytes++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (in_gaps_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_line_result(b);
        bytes_sent++;
    endtask

    // Sends a string; zero_at picks one position to replace with a NUL byte.
    task automatic send_text(input string s, input int zero_at = -1);
        for (int i = 0; i < s.len(); i++)
        begin
            if (i == zero_at)
                send_byte(CHAR_NUL);
            else
                send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] nmea_xor(input string body);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < body.len(); i++)
            acc = acc ^ body[i];
        return acc;
    endfunction

    function automatic string framed(input string body);
        return {"$", body, "*", $sformatf("%02X", nmea_xor(body))};
    endfunction

    function automatic string repeat_char(input string ch, input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, ch};
        return s;
    endfunction

    // Printable filler without field or checksum delimiters.
    function automatic string rand_text(input int n);
        string s;
        byte   c;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            c = byte'($urandom_range(8'h20, 8'h7E));
            if (c == CHAR_STAR || c == CHAR_COMMA)
                c = "0";
            s = {s, $sformatf("%c", c)};
        end
        return s;
    endfunction

    function automatic string random_sentence();
        string      body;
        string      hdr;
        string      stat;
        logic [7:0] sum;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 4)
            hdr = "GPRMC";
        else if (r < 8)
            hdr = "GNRMC";
        else if (r == 8)
        begin
            case ($urandom_range(0, 4))
                0: hdr = "GPGGA";
                1: hdr = "GPRM";
                2: hdr = "GPRMCC";
                3: hdr = "GNRMA";
                default: hdr = "gprmc";
            endcase
        end
        else
            hdr = rand_text($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        if (r < 5)
            stat = "A";
        else if (r < 8)
            stat = "V";
        else if (r == 8)
            stat = "";
        else
            stat = rand_text(1);
        if ($urandom_range(0, 11) == 0)
            body = {hdr, ",", rand_text($urandom_range(0, 8))};
        else
        begin
            body = {hdr, ",", rand_text($urandom_range(0, 10)), ",", stat};
            repeat ($urandom_range(0, 6))
                body = {body, ",", rand_text($urandom_range(0, 12))};
        end
        // Now and then a long line to reach the buffer limit.
        if ($urandom_range(0, 15) == 0)
            body = {body, ",", rand_text($urandom_range(40, 125))};
        sum = nmea_xor(body);
        r = $urandom_range(0, 99);
        if (r < 78)
            return {"$", body, "*", $sformatf("%02X", sum)};
        else if (r < 86)
            return {"$", body, "*", $sformatf("%02x", sum)};
        else if (r < 91)
            return {"$", body, "*", $sformatf("%02X", sum ^ 8'($urandom_range(1, 255)))};
        else if (r < 95)
            return {"$", body, "*", $sformatf("%1X", sum[3:0]), rand_text($urandom_range(0, 2))};
        else if (r < 97)
            return {rand_text(1), body, "*", $sformatf("%02X", sum)};
        else
            return {"$", body};
    endfunction

    task automatic random_traffic(input int n_bytes);
        string text;
        int    stop_at;
        int    kind;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            text = random_sentence();
            if (kind >= 80 && kind < 90)
                text = text.substr(0, $urandom_range(0, text.len() - 1));
            else if (kind >= 90)
            begin
                // Raw noise, terminators and NUL bytes included.
                repeat ($urandom_range(0, 40))
                    send_byte(8'($urandom_range(0, 255)));
                text = "";
            end
            send_text(text, ($urandom_range(0, 29) == 0) ? $urandom_range(0, text.len()) : -1);
            case ($urandom_range(0, 2))
                0: send_text("\r\n");
                1: send_byte(CHAR_LF);
                default: send_byte(CHAR_CR);
            endcase
        end
    endtask

    task automatic test_well_formed_lines();
        send_text({framed("GPRMC,123519,A,4807.038,N,01131.000,E"), "\r\n"});
        send_text({framed("GNRMC,235959,V,,"), "\n"});
        send_text({framed("GNRMC,000000,A"), "\r"});
    endtask

    task automatic test_checksum_cases();
        send_text({"$GPRMC,1,A,zz*", $sformatf("%02x", nmea_xor("GPRMC,1,A,zz")), "\r"});
        send_text({"$GPRMC,1,A*", $sformatf("%02X", nmea_xor("GPRMC,1,A") ^ 8'h01), "\r"});
        send_text({"!GPRMC,1,A*", $sformatf("%02X", nmea_xor("GPRMC,1,A")), "\r"});
        send_text("$GPRMC,1,A,55\r");
        // The body GPGP has a zero XOR, so a missing or unreadable checksum still passes.
        send_text("$GPGP*0,\r");
        send_text("$GPGP*G\r");
        send_text("$GPGP*\r");
        send_text("$GPGP*004\r");
        send_text("$GPGP*1F\r");
    endtask

    task automatic test_header_and_status();
        send_text({framed("GPGGA,1,A"), "\r"});
        send_text({framed("GPRM,1,A"), "\r"});
        send_text({framed("GPRMCX,1,A"), "\r"});
        send_text({framed("GPRMC,12"), "\r"});
        send_text({framed("GNRMC,12,a"), "\n"});
        send_text({framed("GPRMC,,,A"), "\n"});
    endtask

    task automatic test_length_limits();
        send_text("$GP*1\n");
        send_text("$GP*10\n");
        send_text("\r\n\r");
        send_text({framed({"GPRMC,1,A,", repeat_char("X", 113)}), "\r"});
        // The dollar sign lands on a full buffer and is dropped.
        send_text({repeat_char("X", 127), framed("GPRMC,1,A"), "\r"});
    endtask

    task automatic test_byte_extremes();
        send_text(framed("GPRMC,2,A"));
        send_byte(CHAR_NUL);
        send_text("*00,ZZ");
        send_byte(CHAR_CR);
        send_byte(CHAR_NUL);
        send_text("$GPRMC,1,A*00\n");
        send_text("$");
        repeat (6) send_byte(8'hFF);
        send_text("*00\r");
    endtask

    task automatic test_random_traffic();
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
        random_traffic(800);
    endtask

    task automatic test_back_to_back();
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        random_traffic(200);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        parse_st = LINE_CLEAR;
        line_bytes = 0;
        bytes_sent = 0;
        results_seen = 0;
        mismatches = 0;
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
        for (int i = 0; i < 4; i++)
            class_hits[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed_lines();
        test_checksum_cases();
        test_header_and_status();
        test_length_limits();
        test_byte_extremes();
        test_random_traffic();
        test_back_to_back();

        in_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes and checked %0d line results.", bytes_sent, results_seen);
        $display("Results by class: bad sum %0d, not RMC %0d, void %0d, active %0d.",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3]);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nmea_rmc_pkg.sv
sv/nmea_rmc_line_checker.sv
dv/testbench.sv
